/* hdl/lcdseq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lcdseq_pkg;

    // request kinds on the input stream
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_BYTE   = 3'd1;
    localparam logic [2:0] CMD_DATA   = 3'd2;
    localparam logic [2:0] CMD_CURSOR = 3'd3;
    localparam logic [2:0] CMD_DIGIT  = 3'd4;

    // geometry register codes
    localparam logic [1:0] GEOM_16X2 = 2'd0;
    localparam logic [1:0] GEOM_16X4 = 2'd1;
    localparam logic [1:0] GEOM_20X4 = 2'd2;

    // waits in microseconds
    localparam logic [15:0] WAIT_POWER_ON_US = 16'd60000;
    localparam logic [13:0] WAIT_INIT_0_US   = 14'd5000;
    localparam logic [13:0] WAIT_SHORT_US    = 14'd1000;
    localparam logic [13:0] WAIT_LONG_US     = 14'd2000;
    localparam logic [13:0] WAIT_CLEAR_US    = 14'd10000;
    localparam logic [13:0] WAIT_NONE_US     = 14'd0;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] SET_DDRAM  = 8'h80;
    localparam logic [7:0] SLOW_LIMIT = 8'h03;

    // op queue between front and back
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // one byte (or single init nibble) to be strobed out
    typedef struct packed {
        logic        rs;
        logic [7:0]  data;
        logic        single;      // one strobe only, low nibble
        logic        first;       // power-on wait before it
        logic [13:0] wait_after;
        logic        last;
    } lcdseq_op_t;

    localparam logic [7:0] GLYPH_CODES [10][6] = '{
        '{8'd0,   8'd1, 8'd2,   8'd0,   8'd4,   8'd2},
        '{8'd254, 8'd2, 8'd254, 8'd254, 8'd2,   8'd254},
        '{8'd3,   8'd6, 8'd2,   8'd0,   8'd4,   8'd4},
        '{8'd3,   8'd6, 8'd2,   8'd7,   8'd4,   8'd2},
        '{8'd0,   8'd4, 8'd2,   8'd254, 8'd254, 8'd2},
        '{8'd0,   8'd6, 8'd5,   8'd7,   8'd4,   8'd2},
        '{8'd0,   8'd6, 8'd5,   8'd0,   8'd4,   8'd2},
        '{8'd1,   8'd1, 8'd2,   8'd254, 8'd254, 8'd2},
        '{8'd0,   8'd6, 8'd2,   8'd0,   8'd4,   8'd2},
        '{8'd0,   8'd6, 8'd2,   8'd7,   8'd4,   8'd2}
    };

    function automatic logic [7:0] glyph_code(input logic [3:0] digit, input logic [2:0] idx);
        logic [7:0] code;
        code = 8'd0;
        if (digit <= 4'd9 && idx <= 3'd5) begin
            code = GLYPH_CODES[digit][idx];
        end
        return code;
    endfunction

    function automatic logic [7:0] row_offset(input logic [1:0] geom, input logic [1:0] row);
        logic [7:0] off;
        off = 8'h00;
        case (geom)
            GEOM_16X4: begin
                case (row)
                    2'd0:    off = 8'h00;
                    2'd1:    off = 8'h40;
                    2'd2:    off = 8'h10;
                    default: off = 8'h50;
                endcase
            end
            GEOM_20X4: begin
                case (row)
                    2'd0:    off = 8'h00;
                    2'd1:    off = 8'h40;
                    2'd2:    off = 8'h14;
                    default: off = 8'h54;
                endcase
            end
            default: begin
                off = (row == 2'd0) ? 8'h00 : 8'h40;
            end
        endcase
        return off;
    endfunction

    // address wraps at 8 bits
    function automatic logic [7:0] cursor_byte(input logic [1:0] geom, input logic [1:0] row,
                                               input logic [5:0] col);
        return SET_DDRAM + row_offset(geom, row) + {2'b00, col};
    endfunction

    function automatic logic [13:0] cmd_wait(input logic [7:0] b, input logic [13:0] extra);
        return ((b < SLOW_LIMIT) ? WAIT_LONG_US : WAIT_SHORT_US) + extra;
    endfunction

endpackage

`default_nettype wire

/* hdl/lcdseq_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [1:0]        geometry,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [2:0]        req_cmd,
    input  wire logic [7:0]        req_value,
    input  wire logic [1:0]        req_row,
    input  wire logic [5:0]        req_col,
    output logic                   push,
    output lcdseq_pkg::lcdseq_op_t push_op,
    input  wire logic              fifo_full
);

    logic       busy_reg, busy_next;
    logic [3:0] step_reg, step_next;
    logic [2:0] cmd_reg;
    logic [7:0] value_reg;
    logic [1:0] row_reg;
    logic [5:0] col_reg;
    logic       cmd_known;
    logic       is_digit;
    logic [2:0] glyph_idx;

    assign req_ready = !busy_reg;
    assign push      = busy_reg && !fifo_full;

    always_comb begin
        cmd_known = req_cmd inside {[lcdseq_pkg::CMD_INIT : lcdseq_pkg::CMD_DIGIT]};
        is_digit  = value_reg inside {[8'h30 : 8'h39]};
        glyph_idx = (step_reg[2] ? 3'd3 : 3'd0) + {1'b0, step_reg[1:0] - 2'd1};
    end

    always_comb begin
        push_op            = '0;
        push_op.wait_after = lcdseq_pkg::WAIT_NONE_US;
        case (cmd_reg)
            lcdseq_pkg::CMD_INIT: begin
                if (!step_reg[2]) begin
                    // 8-bit mode wake-up, bare nibbles
                    push_op.single = 1'b1;
                    push_op.first  = (step_reg[1:0] == 2'd0);
                    push_op.data   = (step_reg[1:0] == 2'd3) ? 8'h02 : 8'h03;
                    case (step_reg[1:0])
                        2'd0:    push_op.wait_after = lcdseq_pkg::WAIT_INIT_0_US;
                        2'd1:    push_op.wait_after = lcdseq_pkg::WAIT_SHORT_US;
                        default: push_op.wait_after = lcdseq_pkg::WAIT_NONE_US;
                    endcase
                end else begin
                    case (step_reg[1:0])
                        2'd0:    push_op.data = 8'h28;
                        2'd1:    push_op.data = 8'h0c;
                        2'd2:    push_op.data = 8'h06;
                        default: push_op.data = 8'h01;
                    endcase
                    push_op.last       = (step_reg[1:0] == 2'd3);
                    push_op.wait_after = lcdseq_pkg::cmd_wait(push_op.data,
                        push_op.last ? lcdseq_pkg::WAIT_CLEAR_US : lcdseq_pkg::WAIT_NONE_US);
                end
            end
            lcdseq_pkg::CMD_BYTE: begin
                push_op.data       = value_reg;
                push_op.wait_after = lcdseq_pkg::cmd_wait(value_reg, lcdseq_pkg::WAIT_NONE_US);
                push_op.last       = 1'b1;
            end
            lcdseq_pkg::CMD_DATA: begin
                push_op.rs         = 1'b1;
                push_op.data       = value_reg;
                push_op.wait_after = lcdseq_pkg::WAIT_SHORT_US;
                push_op.last       = 1'b1;
            end
            lcdseq_pkg::CMD_CURSOR: begin
                push_op.data       = lcdseq_pkg::cursor_byte(geometry, row_reg, col_reg);
                push_op.wait_after = lcdseq_pkg::cmd_wait(push_op.data, lcdseq_pkg::WAIT_NONE_US);
                push_op.last       = 1'b1;
            end
            lcdseq_pkg::CMD_DIGIT: begin
                // step: [3] glyph half, [2] row, [1:0] cursor then three cells
                if (step_reg[1:0] == 2'd0) begin
                    push_op.data = lcdseq_pkg::cursor_byte(geometry, {1'b0, step_reg[2]},
                                                           col_reg);
                    push_op.wait_after = lcdseq_pkg::cmd_wait(push_op.data,
                                                              lcdseq_pkg::WAIT_NONE_US);
                end else begin
                    push_op.rs         = 1'b1;
                    push_op.data       = step_reg[3] ?
                        lcdseq_pkg::glyph_code(value_reg[3:0], glyph_idx) : lcdseq_pkg::CHAR_SPACE;
                    push_op.wait_after = lcdseq_pkg::WAIT_SHORT_US;
                end
                push_op.last = is_digit ? (step_reg == 4'd15) : (step_reg == 4'd7);
            end
            default: begin
                push_op.last = 1'b1;
            end
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (req_valid && req_ready) begin
            busy_next = cmd_known;
            step_next = 4'd0;
        end else if (push) begin
            step_next = step_reg + 4'd1;
            if (push_op.last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_valid && req_ready) begin
            cmd_reg   <= req_cmd;
            value_reg <= req_value;
            row_reg   <= req_row;
            col_reg   <= req_col;
        end
    end

endmodule

`default_nettype wire

/* hdl/lcdseq_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_fifo (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire lcdseq_pkg::lcdseq_op_t push_op,
    output logic                        full,
    input  wire logic                   pop,
    output lcdseq_pkg::lcdseq_op_t      head_op,
    output logic                        empty
);

    localparam int AW = lcdseq_pkg::FIFO_AW;

    lcdseq_pkg::lcdseq_op_t entry_reg [lcdseq_pkg::FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(lcdseq_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

/* hdl/lcdseq_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire lcdseq_pkg::lcdseq_op_t head_op,
    input  wire logic                   fifo_empty,
    output logic                        pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic                        m_rs_select,
    output logic [3:0]                  m_nibble,
    output logic [15:0]                 m_wait_before_us,
    output logic [13:0]                 m_wait_after_us,
    output logic                        m_last
);

    logic        m_tvalid_reg, m_tvalid_next;
    logic        phase_reg, phase_next;   // high nibble already loaded into the strobe register
    logic        load;
    logic        rs_reg;
    logic [3:0]  nibble_reg;
    logic [15:0] before_reg;
    logic [13:0] after_reg;
    logic        last_reg;

    assign load = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        phase_next    = phase_reg;
        pop           = 1'b0;
        if (load) begin
            m_tvalid_next = !fifo_empty;
            if (!fifo_empty) begin
                if (head_op.single || phase_reg) begin
                    pop        = 1'b1;
                    phase_next = 1'b0;
                end else begin
                    phase_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !fifo_empty) begin
            rs_reg <= head_op.rs;
            if (head_op.single || phase_reg) begin
                nibble_reg <= head_op.data[3:0];
                before_reg <= head_op.first ? lcdseq_pkg::WAIT_POWER_ON_US : 16'd0;
                after_reg  <= head_op.wait_after;
                last_reg   <= head_op.last;
            end else begin
                nibble_reg <= head_op.data[7:4];
                before_reg <= 16'd0;
                after_reg  <= lcdseq_pkg::WAIT_NONE_US;
                last_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid         = m_tvalid_reg;
    assign m_rs_select      = rs_reg;
    assign m_nibble         = nibble_reg;
    assign m_wait_before_us = before_reg;
    assign m_wait_after_us  = after_reg;
    assign m_last           = last_reg;

    a_pop_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_empty)
        else $error("pop from empty op queue");

    a_phase_holds_head: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> !fifo_empty)
        else $error("low nibble pending without an op at the head");

    a_power_on_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && before_reg != 16'd0) |-> (nibble_reg == 4'h3 && !rs_reg))
        else $error("power-on wait on a strobe other than the wake-up nibble");

    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && last_reg) |-> (after_reg != lcdseq_pkg::WAIT_NONE_US))
        else $error("final strobe of a request without a settle wait");

endmodule

`default_nettype wire

/* hdl/char_lcd_nibble_write_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Character display 4-bit write sequencer.
// Input stream (s_*): one request per item - init sequence, command byte, data
// byte, set cursor or big digit; request kind in tuser, operands in tdata.
// Output stream (m_*): one item per enable strobe,
// nibble plus waits in tdata, RS level in tuser, tlast on the request's final strobe.
// A request gives 0 (unknown kind), 2, 12 (init), 16 (big blank) or 32 (big digit)
// strobes. The front turns a request into byte ops, one per cycle while the queue
// is not full, into a 4-entry queue; the back splits each byte into two strobes (a
// single init nibble into one). A taken request's first strobe passes the front's
// request registers, the queue and the back end's strobe register before it is valid.
// Throughput: one strobe per cycle while m_tready is high and the queue is not empty;
// the back end's strobe register sets this. A new request is taken once the front
// has queued every op of the previous one. When the receiver stalls, the strobe
// register holds, the queue fills and the front and then s_tready stall in turn;
// nothing is dropped. Reset (aresetn low, synchronous) empties the queue, drops any
// request in progress and sets geometry to 16x2. The APB port has a single register,
// geometry, at addresses 0 to 3 (paddr[2] low); pready is always high.
module char_lcd_nibble_write_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // value[7:0], row[9:8], col[15:10]
    input  wire logic [2:0]  s_tuser,   // cmd[2:0]
    // strobe stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // nibble[3:0], wait_before_us[19:4],
                                        // wait_after_us[33:20], zero
    output logic             m_tuser,   // rs_select
    output logic             m_tlast    // last
);

    logic [1:0]  geometry_reg;
    logic        cfg_write;

    logic                   push, fifo_full, fifo_empty, pop;
    lcdseq_pkg::lcdseq_op_t push_op, head_op;

    logic [3:0]  nibble;
    logic [15:0] wait_before_us;
    logic [13:0] wait_after_us;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : {30'd0, geometry_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geometry_reg <= lcdseq_pkg::GEOM_16X2;
        end else if (cfg_write) begin
            geometry_reg <= pwdata[1:0];
        end
    end

    lcdseq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .geometry  (geometry_reg),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_cmd   (s_tuser),
        .req_value (s_tdata[7:0]),
        .req_row   (s_tdata[9:8]),
        .req_col   (s_tdata[15:10]),
        .push      (push),
        .push_op   (push_op),
        .fifo_full (fifo_full)
    );

    lcdseq_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .full    (fifo_full),
        .pop     (pop),
        .head_op (head_op),
        .empty   (fifo_empty)
    );

    lcdseq_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_op          (head_op),
        .fifo_empty       (fifo_empty),
        .pop              (pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_rs_select      (m_tuser),
        .m_nibble         (nibble),
        .m_wait_before_us (wait_before_us),
        .m_wait_after_us  (wait_after_us),
        .m_last           (m_tlast)
    );

    assign m_tdata = {6'd0, wait_after_us, wait_before_us, nibble};

endmodule

`default_nettype wire
